### src/mfel_pkg.sv
// Shared widths, defaults and the point store entry layout for the
// morse_forest_edge_labeler block. No dependencies.
package mfel_pkg;

    localparam int DEF_POINTS = 4096;
    localparam int DEF_EDGES  = 16384;

    localparam int POINT_W  = 12;
    localparam int EDGE_W   = 14;
    localparam int LABEL_W  = 13;
    localparam int VALUE_W  = 32;
    localparam int FCOUNT_W = 15;

    // One entry per mesh point; all fields are rewritten together.
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [POINT_W-1:0] parent;
        logic [EDGE_W-1:0]  pedge;
    } entry_t;

endpackage

### src/mfel_point_store.sv
// Point store: label, parent and parent edge per point, one write port and
// two registered read ports. Depends on mfel_pkg.
module mfel_point_store import mfel_pkg::*; #(
    parameter int POINTS = DEF_POINTS,
    localparam int PTR_W = $clog2(POINTS)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr_a,
    input  logic [PTR_W-1:0] rd_addr_b,
    output entry_t           rd_data_a,
    output entry_t           rd_data_b
);

    entry_t mem [POINTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### src/morse_forest_edge_labeler.sv
// Maximum spanning forest labeler over edges fed in descending value order.
// Depends on mfel_pkg and mfel_point_store.
//
// Per item: an edge reads both endpoint entries in the accept cycle, and the
// next cycle evaluates and writes the point store; an edge that starts a new
// tree then also writes its second entry, since its two endpoint entries go
// through the single write port one after the other. A query reads and
// evaluates its entry the same way, with no write. A clear sweeps the point
// store one entry a cycle and replies once the last entry is written. After
// reset the same sweep runs over all POINTS entries and no transaction is
// accepted until it ends. A finished result waits in the output register;
// the block accepts the next item meanwhile and only holds once it has the
// following result ready. func 3 is accepted and dropped with no reply.
module morse_forest_edge_labeler import mfel_pkg::*; #(
    parameter int POINTS = DEF_POINTS,
    parameter int EDGES  = DEF_EDGES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // edge_index[13:0], from_point[25:14], to_point[37:26],
    // from_value[69:38], to_value[101:70], edge_value[133:102], zeros above
    input  logic [135:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tree_source[11:0], tree_target[23:12], edge_out[37:24],
    // root_label[50:38], forest_edges[65:51], order_error[66], zeros above
    output logic [71:0]  m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser
);

    localparam int PTR_W = $clog2(POINTS);
    localparam int XW    = (PTR_W > POINT_W) ? PTR_W : POINT_W;
    localparam int CNT_W = $clog2(EDGES + 1);
    localparam int CX    = (CNT_W > FCOUNT_W) ? CNT_W : FCOUNT_W;

    typedef enum logic [1:0] {
        FN_EDGE  = 2'd0,
        FN_QUERY = 2'd1,
        FN_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        K_SAME   = 3'd0,
        K_NEW    = 3'd1,
        K_EXTEND = 3'd2,
        K_SADDLE = 3'd3,
        K_QUERY  = 3'd4,
        K_CLEAR  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_WR2,
        S_CLEAR,
        S_EMIT
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [POINT_W-1:0]  src;
        logic [POINT_W-1:0]  dst;
        logic [EDGE_W-1:0]   edge_out;
        logic [LABEL_W-1:0]  label;
        logic [FCOUNT_W-1:0] fcount;
        logic                err;
    } res_t;

    function automatic logic [PTR_W-1:0] to_addr(input logic [POINT_W-1:0] p);
        logic [XW-1:0] x;
        x = XW'(p);
        return x[PTR_W-1:0];
    endfunction

    function automatic logic in_range(input logic [POINT_W-1:0] p);
        return {20'b0, p} < 32'(POINTS);
    endfunction

    function automatic logic [FCOUNT_W-1:0] to_fcount(input logic [CNT_W-1:0] c);
        logic [CX-1:0] x;
        x = CX'(c);
        return x[FCOUNT_W-1:0];
    endfunction

    // input fields
    logic [EDGE_W-1:0]         in_edge;
    logic [POINT_W-1:0]        in_p1, in_p2;
    logic signed [VALUE_W-1:0] in_v1, in_v2, in_ev;
    func_t                     in_func;

    assign in_edge = s_axis_tdata[13:0];
    assign in_p1   = s_axis_tdata[25:14];
    assign in_p2   = s_axis_tdata[37:26];
    assign in_v1   = s_axis_tdata[69:38];
    assign in_v2   = s_axis_tdata[101:70];
    assign in_ev   = s_axis_tdata[133:102];
    assign in_func = func_t'(s_axis_tuser);

    // registers
    state_t                    state_reg, state_next;
    logic [PTR_W-1:0]          ptr_reg, ptr_next;
    func_t                     func_reg, func_next;
    logic [EDGE_W-1:0]         edge_reg, edge_next;
    logic [POINT_W-1:0]        p1_reg, p1_next, p2_reg, p2_next;
    logic                      ok_reg, ok_next;
    logic                      vgt_reg, vgt_next;
    logic                      err_reg, err_next;
    logic signed [VALUE_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [PTR_W-1:0]          leaf_addr_reg, leaf_addr_next;
    entry_t                    leaf_entry_reg, leaf_entry_next;
    res_t                      res_reg, res_next;
    res_t                      out_reg, out_next;
    logic                      m_valid_reg, m_valid_next;

    // store port
    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           rd_a, rd_b;

    // evaluation
    logic               out_free, fin;
    res_t               res_now;
    logic [CNT_W-1:0]   count_inc;
    logic [POINT_W-1:0] root, leaf, ext_src, ext_dst;
    logic [LABEL_W-1:0] new_label, ext_label;

    mfel_point_store #(
        .POINTS (POINTS)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (to_addr(in_p1)),
        .rd_addr_b (to_addr(in_p2)),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign count_inc = (count_reg != CNT_W'(EDGES)) ? count_reg + 1'b1 : count_reg;

    assign root      = vgt_reg ? p1_reg : p2_reg;
    assign leaf      = vgt_reg ? p2_reg : p1_reg;
    assign new_label = {1'b0, root} + 1'b1;
    assign ext_src   = (rd_a.label == '0) ? p2_reg : p1_reg;
    assign ext_dst   = (rd_a.label == '0) ? p1_reg : p2_reg;
    assign ext_label = (rd_a.label == '0) ? rd_b.label : rd_a.label;

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        func_next       = func_reg;
        edge_next       = edge_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        ok_next         = ok_reg;
        vgt_next        = vgt_reg;
        err_next        = err_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        leaf_addr_next  = leaf_addr_reg;
        leaf_entry_next = leaf_entry_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        fin             = 1'b0;
        res_now         = '0;
        s_axis_tready   = (state_reg == S_IDLE);

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                if (ptr_reg == PTR_W'(POINTS - 1)) begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_axis_tvalid) begin
                    rd_en     = 1'b1;
                    edge_next = in_edge;
                    p1_next   = in_p1;
                    p2_next   = in_p2;
                    vgt_next  = in_v1 > in_v2;
                    unique case (in_func)
                        FN_EDGE: begin
                            func_next  = FN_EDGE;
                            ok_next    = in_range(in_p1) && in_range(in_p2);
                            err_next   = in_ev > last_reg;
                            last_next  = in_ev;
                            state_next = S_EVAL;
                        end
                        FN_QUERY: begin
                            func_next  = FN_QUERY;
                            ok_next    = in_range(in_p1);
                            state_next = S_EVAL;
                        end
                        FN_CLEAR: begin
                            count_next = '0;
                            last_next  = {1'b0, {(VALUE_W-1){1'b1}}};
                            ptr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default: begin
                            // drop the transaction, no reply
                        end
                    endcase
                end
            end

            S_EVAL: begin
                if (func_reg == FN_QUERY) begin
                    res_now.kind   = K_QUERY;
                    res_now.fcount = to_fcount(count_reg);
                    if (ok_reg && rd_a.label != '0) begin
                        res_now.src      = rd_a.parent;
                        res_now.edge_out = rd_a.pedge;
                        res_now.label    = rd_a.label;
                    end
                    fin = 1'b1;
                end else begin
                    res_now.kind   = K_SAME;
                    res_now.err    = err_reg;
                    res_now.fcount = to_fcount(count_reg);
                    if (!ok_reg) begin
                        fin = 1'b1;
                    end else if (rd_a.label == '0 && rd_b.label == '0) begin
                        // root entry now, leaf entry next cycle
                        wr_en                 = 1'b1;
                        wr_addr               = to_addr(root);
                        wr_data               = '{new_label, root, edge_reg};
                        leaf_addr_next        = to_addr(leaf);
                        leaf_entry_next       = '{new_label, root, edge_reg};
                        count_next            = count_inc;
                        res_now.kind          = K_NEW;
                        res_now.src           = root;
                        res_now.dst           = leaf;
                        res_now.edge_out      = edge_reg;
                        res_now.label         = new_label;
                        res_now.fcount        = to_fcount(count_inc);
                        res_next              = res_now;
                        state_next            = S_WR2;
                    end else if (rd_a.label == '0 || rd_b.label == '0) begin
                        wr_en            = 1'b1;
                        wr_addr          = to_addr(ext_dst);
                        wr_data          = '{ext_label, ext_src, edge_reg};
                        count_next       = count_inc;
                        res_now.kind     = K_EXTEND;
                        res_now.src      = ext_src;
                        res_now.dst      = ext_dst;
                        res_now.edge_out = edge_reg;
                        res_now.label    = ext_label;
                        res_now.fcount   = to_fcount(count_inc);
                        fin              = 1'b1;
                    end else if (rd_a.label != rd_b.label) begin
                        res_now.kind     = K_SADDLE;
                        res_now.edge_out = edge_reg;
                        fin              = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end

            S_WR2: begin
                wr_en   = 1'b1;
                wr_addr = leaf_addr_reg;
                wr_data = leaf_entry_reg;
                res_now = res_reg;
                fin     = 1'b1;
            end

            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                if (ptr_reg == PTR_W'(POINTS - 1)) begin
                    ptr_next     = '0;
                    res_now.kind = K_CLEAR;
                    fin          = 1'b1;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result to the output register, or park it until free
        if (fin) begin
            if (out_free) begin
                out_next     = res_now;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end else begin
                res_next   = res_now;
                state_next = S_EMIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            ptr_reg     <= '0;
            count_reg   <= '0;
            last_reg    <= {1'b0, {(VALUE_W-1){1'b1}}};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg       <= func_next;
        edge_reg       <= edge_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        ok_reg         <= ok_next;
        vgt_reg        <= vgt_next;
        err_reg        <= err_next;
        leaf_addr_reg  <= leaf_addr_next;
        leaf_entry_reg <= leaf_entry_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {5'b0, out_reg.err, out_reg.fcount, out_reg.label,
                            out_reg.edge_out, out_reg.dst, out_reg.src};

endmodule

### sim/morse_forest_edge_labeler_test.sv
// Self-checking bench for morse_forest_edge_labeler: streams edges, queries and
// clears with random gaps and stalls, and checks each reply against a forest model.
// Depends on mfel_pkg and the labeler RTL.
`timescale 1ns / 100ps

module morse_forest_edge_labeler_test;
    import mfel_pkg::*;

    localparam int WATCHDOG_LIMIT = 5 * DEF_POINTS;
    localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    typedef enum logic [1:0] {FN_EDGE, FN_QUERY, FN_CLEAR, FN_SPARE} func_t;
    typedef enum logic [2:0] {
        K_SAME_TREE, K_NEW_TREE, K_EXTEND, K_SADDLE, K_QUERY, K_CLEARED
    } kind_t;

    typedef struct {
        func_t              func;
        logic [EDGE_W-1:0]  edge_idx;
        logic [POINT_W-1:0] p_from;
        logic [POINT_W-1:0] p_to;
        logic signed [31:0] v_from;
        logic signed [31:0] v_to;
        logic signed [31:0] v_edge;
        int                 gap;
        bit                 drain;
    } edge_item_t;

    typedef struct packed {
        kind_t               kind;
        logic [POINT_W-1:0]  src;
        logic [POINT_W-1:0]  dst;
        logic [EDGE_W-1:0]   edge_out;
        logic [LABEL_W-1:0]  root_label;
        logic [FCOUNT_W-1:0] forest_edges;
        logic                order_error;
    } forest_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    morse_forest_edge_labeler dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // forest model state
    logic [LABEL_W-1:0]  point_label [DEF_POINTS] = '{default: '0};
    logic [POINT_W-1:0]  point_parent [DEF_POINTS];
    logic [EDGE_W-1:0]   point_pedge [DEF_POINTS];
    logic [FCOUNT_W-1:0] forest_total = '0;
    logic signed [31:0]  prev_edge_value = MAXV;

    edge_item_t     pending_items[$];
    forest_result_t expected_results[$];
    edge_item_t     in_flight;
    int             n_predicted = 0;
    int             n_checked = 0;
    int             fail_count = 0;
    bit             sender_calm = 1'b0;

    function automatic void label_forest(input edge_item_t it, output forest_result_t r,
                                         output bit produces);
        logic [LABEL_W-1:0] la, lb, lab;
        logic [POINT_W-1:0] root, leaf, src, dst;
        r = '0;
        produces = 1'b1;
        case (it.func)
            FN_EDGE: begin
                r.order_error = (it.v_edge > prev_edge_value);
                prev_edge_value = it.v_edge;
                la = point_label[it.p_from];
                lb = point_label[it.p_to];
                if (la == 0 && lb == 0) begin
                    // higher endpoint becomes root, ties go to the second one
                    root = (it.v_from > it.v_to) ? it.p_from : it.p_to;
                    leaf = (root == it.p_from) ? it.p_to : it.p_from;
                    lab = {1'b0, root} + 13'd1;
                    point_parent[root] = root;
                    point_pedge[root] = it.edge_idx;
                    point_parent[leaf] = root;
                    point_pedge[leaf] = it.edge_idx;
                    point_label[it.p_from] = lab;
                    point_label[it.p_to] = lab;
                    if (forest_total < FCOUNT_W'(DEF_EDGES)) forest_total++;
                    r.kind = K_NEW_TREE;
                    r.src = root;
                    r.dst = leaf;
                    r.edge_out = it.edge_idx;
                    r.root_label = lab;
                end else if (la == 0 || lb == 0) begin
                    src = (la == 0) ? it.p_to : it.p_from;
                    dst = (la == 0) ? it.p_from : it.p_to;
                    lab = (la == 0) ? lb : la;
                    point_label[dst] = lab;
                    point_parent[dst] = src;
                    point_pedge[dst] = it.edge_idx;
                    if (forest_total < FCOUNT_W'(DEF_EDGES)) forest_total++;
                    r.kind = K_EXTEND;
                    r.src = src;
                    r.dst = dst;
                    r.edge_out = it.edge_idx;
                    r.root_label = lab;
                end else if (la != lb) begin
                    r.kind = K_SADDLE;
                    r.edge_out = it.edge_idx;
                end else begin
                    r.kind = K_SAME_TREE;
                end
            end
            FN_QUERY: begin
                r.kind = K_QUERY;
                if (point_label[it.p_from] != 0) begin
                    r.src = point_parent[it.p_from];
                    r.edge_out = point_pedge[it.p_from];
                    r.root_label = point_label[it.p_from];
                end
            end
            FN_CLEAR: begin
                foreach (point_label[i]) point_label[i] = '0;
                forest_total = '0;
                prev_edge_value = MAXV;
                r.kind = K_CLEARED;
            end
            default: produces = 1'b0;
        endcase
        r.forest_edges = forest_total;
    endfunction

    task automatic add_item(input func_t f, input logic [EDGE_W-1:0] idx,
                            input logic [POINT_W-1:0] pa, input logic [POINT_W-1:0] pb,
                            input logic signed [31:0] fv, input logic signed [31:0] tv,
                            input logic signed [31:0] ev, input bit drain = 1'b0);
        edge_item_t it;
        it.func = f;
        it.edge_idx = idx;
        it.p_from = pa;
        it.p_to = pb;
        it.v_from = fv;
        it.v_to = tv;
        it.v_edge = ev;
        it.gap = sender_calm ? 0 : $urandom_range(0, 5);
        it.drain = drain;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // driver
    int gap_count = 0;
    always @(posedge aclk) begin
        forest_result_t res;
        bit produces;
        produces = 1'b0;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            gap_count = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                label_forest(in_flight, res, produces);
                if (produces) begin
                    expected_results.insert(expected_results.size(), res);
                    n_predicted <= n_predicted + 1;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && gap_count < pending_items[0].gap) begin
                    gap_count++;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0 && (!pending_items[0].drain ||
                             (n_predicted == n_checked && !produces))) begin
                    in_flight = pending_items.pop_front();
                    s_axis_tdata <= {2'b00, in_flight.v_edge, in_flight.v_to, in_flight.v_from,
                                     in_flight.p_to, in_flight.p_from, in_flight.edge_idx};
                    s_axis_tuser <= in_flight.func;
                    s_axis_tvalid <= 1'b1;
                    gap_count = 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    int  stall_count = 0;
    int  results_seen = 0;
    bit  rx_calm = 1'b0;
    always @(posedge aclk) begin
        forest_result_t seen, want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_count = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind = kind_t'(m_axis_tuser);
                seen.src = m_axis_tdata[11:0];
                seen.dst = m_axis_tdata[23:12];
                seen.edge_out = m_axis_tdata[37:24];
                seen.root_label = m_axis_tdata[50:38];
                seen.forest_edges = m_axis_tdata[65:51];
                seen.order_error = m_axis_tdata[66];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d",
                             $time, seen.kind);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, seen.kind);
                    check_field("tree_source", want.src, seen.src);
                    check_field("tree_target", want.dst, seen.dst);
                    check_field("edge_out", want.edge_out, seen.edge_out);
                    check_field("root_label", want.root_label, seen.root_label);
                    check_field("forest_edges", want.forest_edges, seen.forest_edges);
                    check_field("order_error", want.order_error, seen.order_error);
                    n_checked <= n_checked + 1;
                end
                results_seen++;
                if (results_seen % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                stall_count = rx_calm ? 0 : $urandom_range(0, 5);
            end
            if (stall_count > 0) begin
                stall_count--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: the reset sweep and every clear sweep all POINTS entries with no transaction
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int n_random;
        int pick, win, len;
        logic [POINT_W-1:0] base, pa, pb;
        logic signed [31:0] ev_run, fv, tv;
        longint nxt;

        // directed: runs from the reset state
        add_item(FN_EDGE, 0, 0, 4095, MINV, MAXV, MAXV);
        add_item(FN_EDGE, 16383, 1, 2, 32'sh50000, 32'sh50000, MAXV - 1);  // tie
        add_item(FN_EDGE, 7, 3, 3, -1, 0, 32'sh640000);                      // self loop, new
        add_item(FN_EDGE, 8, 3, 3, 0, 0, 32'sh640000);                       // self loop, labeled
        add_item(FN_EDGE, 9, 4, 0, 1, 2, 32'sh5A0000);                       // extend to 4
        add_item(FN_EDGE, 10, 2, 5, 3, 3, 32'sh500000);                      // extend to 5
        add_item(FN_EDGE, 11, 4, 5, 0, 0, 32'sh460000);                      // saddle
        add_item(FN_EDGE, 12, 0, 4, 0, 0, 32'sh460000);                      // same tree
        add_item(FN_EDGE, 13, 6, 7, MAXV, MINV, MAXV);                       // out of order
        add_item(FN_QUERY, 0, 4095, 0, 0, 0, 0);
        add_item(FN_QUERY, 0, 0, 0, 0, 0, 0);
        add_item(FN_QUERY, 0, 4, 0, 0, 0, 0);
        add_item(FN_QUERY, 16383, 100, 4095, MAXV, MINV, MINV);
        add_item(FN_QUERY, 0, 3, 0, 0, 0, 0);
        add_item(FN_SPARE, 16383, 4095, 4095, MINV, MAXV, MAXV);
        add_item(FN_EDGE, 14, 8, 9, 0, 0, MINV);
        add_item(FN_EDGE, 15, 9, 10, 0, 0, MINV);
        add_item(FN_CLEAR, 0, 0, 0, 0, 0, 0);
        add_item(FN_QUERY, 0, 0, 0, 0, 0, 0, 1'b1);                          // drain first
        add_item(FN_EDGE, 16, 0, 1, 7, -7, MAXV);
        add_item(FN_QUERY, 0, 1, 0, 0, 0, 0);

        // random: rounds of descending edges over a small window of points
        n_random = 0;
        while (n_random < 700) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            ev_run = $urandom;
            add_item(FN_CLEAR, EDGE_W'($urandom), POINT_W'($urandom), POINT_W'($urandom),
                     $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
            win = $urandom_range(4, 48);
            base = POINT_W'($urandom_range(0, DEF_POINTS - 64));
            len = $urandom_range(20, 70);
            n_random++;
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    pa = (pick < 2) ? POINT_W'($urandom)
                                    : POINT_W'(base + $urandom_range(0, win - 1));
                    add_item(FN_QUERY, EDGE_W'($urandom), pa, POINT_W'($urandom),
                             $urandom, $urandom, $urandom, $urandom_range(0, 49) == 0);
                end else if (pick < 12) begin
                    add_item(FN_SPARE, EDGE_W'($urandom), POINT_W'($urandom),
                             POINT_W'($urandom), $urandom, $urandom, $urandom);
                end else begin
                    if (pick < 15) begin
                        pa = POINT_W'($urandom);
                        pb = POINT_W'($urandom);
                    end else begin
                        pa = POINT_W'(base + $urandom_range(0, win - 1));
                        pb = (pick < 19) ? pa : POINT_W'(base + $urandom_range(0, win - 1));
                    end
                    fv = $urandom;
                    tv = (pick < 24) ? fv : $urandom;
                    if (pick > 96) begin
                        ev_run = $urandom;  // may break the order
                    end else begin
                        nxt = longint'(ev_run) - longint'($urandom_range(0, 1 << 18));
                        if (nxt < longint'(MINV)) nxt = longint'(MINV);
                        ev_run = nxt[31:0];
                    end
                    add_item(FN_EDGE, EDGE_W'($urandom), pa, pb, fv, tv, ev_run,
                             $urandom_range(0, 49) == 0);
                end
                n_random++;
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (n_checked != n_predicted) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results expected, got none", $time, expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
